/* rtl/core/sha256_pkg.sv */
// SHA-256 engine package: working-variable type, schedule control type,
// round constants, initial hash values and the sigma functions.
// No dependencies.
package sha256_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    typedef struct packed {
        logic       load_byte;
        logic       advance;
        logic [7:0] byte_val;
    } sched_ctl_t;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARKER   = 8'h80;
    localparam logic [5:0] LEN_FIELD_AT = 6'd56;
    localparam logic [5:0] LAST_SLOT    = 6'd63;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [2:0] LAST_WORD    = 3'd7;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* rtl/core/sha256_sched.sv */
// SHA-256 message schedule: 16-word shift line that packs message bytes
// and then expands the schedule one word per round. Depends on sha256_pkg.
module sha256_sched (
    input  logic                   clk,
    input  sha256_pkg::sched_ctl_t ctl,
    output logic [31:0]            w_cur
);
    import sha256_pkg::*;

    logic [31:0] sched_reg  [0:15];
    logic [31:0] sched_next [0:15];
    logic [31:0] w_new;

    assign w_cur = sched_reg[0];
    assign w_new = small_sigma1(sched_reg[14]) + sched_reg[9]
                 + small_sigma0(sched_reg[1]) + sched_reg[0];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sched_next[i] = sched_reg[i];
        end
        if (ctl.load_byte)
        begin
            // shift the whole block left by one byte, new byte at the tail
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = {sched_reg[i][23:0], sched_reg[i+1][31:24]};
            end
            sched_next[15] = {sched_reg[15][23:0], ctl.byte_val};
        end
        else if (ctl.advance)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = sched_reg[i+1];
            end
            sched_next[15] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            sched_reg[i] <= sched_next[i];
        end
    end

endmodule

/* rtl/core/sha256_round.sv */
// SHA-256 round function: one compression round on the working variables.
// Depends on sha256_pkg.
module sha256_round (
    input  sha256_pkg::work_t cur,
    input  logic [31:0]       k_val,
    input  logic [31:0]       w_val,
    output sha256_pkg::work_t nxt
);
    import sha256_pkg::*;

    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    assign ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
    assign maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    assign t1  = cur.h + big_sigma1(cur.e) + ch + k_val + w_val;
    assign t2  = big_sigma0(cur.a) + maj;

    always_comb
    begin
        nxt.h = cur.g;
        nxt.g = cur.f;
        nxt.f = cur.e;
        nxt.e = cur.d + t1;
        nxt.d = cur.c;
        nxt.c = cur.b;
        nxt.b = cur.a;
        nxt.a = t1 + t2;
    end

endmodule

/* rtl/core/sha256_hash_engine.sv */
// SHA-256 streaming engine, top level: sequencer, hash state, working registers.
// A byte beat that fills a block starts compression: 64 rounds, then the hash add.
// End of message: one pad byte per cycle to byte 63, then compression; an extra block
// when fewer than 9 bytes remain; then 8 digest beats. The round unit sets the rate.
// Reset (rst_n low, async): initial hash values, empty block, zero length, idle.
module sha256_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    state_t      state_reg,   state_next;
    logic [31:0] hash_reg     [0:7];
    logic [31:0] hash_next    [0:7];
    logic [5:0]  fill_reg,    fill_next;
    logic [60:0] len_reg,     len_next;
    logic [5:0]  round_reg,   round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_reg,     pad_next;     // message closed, padding under way
    logic        marker_reg,  marker_next;  // 0x80 marker already placed
    logic        final_reg,   final_next;   // current block carries the length
    work_t       work_reg,    work_next;

    sched_ctl_t  sched_ctl;
    logic [31:0] w_cur;
    work_t       round_out;
    work_t       hash_as_work;
    logic [63:0] bit_len;
    logic [7:0]  pad_byte;

    sha256_sched u_sched (
        .clk   (clk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    sha256_round u_round (
        .cur   (work_reg),
        .k_val (ROUND_K[round_reg]),
        .w_val (w_cur),
        .nxt   (round_out)
    );

    assign hash_as_work = '{a: hash_reg[0], b: hash_reg[1], c: hash_reg[2], d: hash_reg[3],
                            e: hash_reg[4], f: hash_reg[5], g: hash_reg[6], h: hash_reg[7]};

    // Length field: bit count, big-endian in slots 56..63 of the final block.
    assign bit_len = {len_reg, 3'b000};

    always_comb
    begin
        if (!marker_reg)
        begin
            pad_byte = PAD_MARKER;
        end
        else if (final_reg && (fill_reg >= LEN_FIELD_AT))
        begin
            pad_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = hash_reg[out_idx_reg];
    assign word_number = out_idx_reg;
    assign final_word  = (out_idx_reg == LAST_WORD);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        pad_next     = pad_reg;
        marker_next  = marker_reg;
        final_next   = final_reg;
        work_next    = work_reg;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
        end
        sched_ctl = '{load_byte: 1'b0, advance: 1'b0, byte_val: data_byte};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pad_next    = end_of_message;
                    marker_next = 1'b0;
                    final_next  = 1'b0;
                    if (byte_present)
                    begin
                        sched_ctl.load_byte = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 61'd1;
                    end
                    if (byte_present && (fill_reg == LAST_SLOT))
                    begin
                        // block full: compress before anything else
                        state_next = S_ROUND;
                        round_next = '0;
                        work_next  = hash_as_work;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                sched_ctl.load_byte = 1'b1;
                sched_ctl.byte_val  = pad_byte;
                fill_next   = fill_reg + 6'd1;
                marker_next = 1'b1;
                // marker with room left for the length: this is the last block
                if (!marker_reg && (fill_reg < LEN_FIELD_AT))
                begin
                    final_next = 1'b1;
                end
                if (fill_reg == LAST_SLOT)
                begin
                    state_next = S_ROUND;
                    round_next = '0;
                    work_next  = hash_as_work;
                end
            end
            S_ROUND:
            begin
                sched_ctl.advance = 1'b1;
                work_next  = round_out;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                hash_next[0] = hash_reg[0] + work_reg.a;
                hash_next[1] = hash_reg[1] + work_reg.b;
                hash_next[2] = hash_reg[2] + work_reg.c;
                hash_next[3] = hash_reg[3] + work_reg.d;
                hash_next[4] = hash_reg[4] + work_reg.e;
                hash_next[5] = hash_reg[5] + work_reg.f;
                hash_next[6] = hash_reg[6] + work_reg.g;
                hash_next[7] = hash_reg[7] + work_reg.h;
                if (!pad_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (final_reg)
                begin
                    state_next   = S_OUT;
                    out_idx_next = '0;
                end
                else
                begin
                    // extra block: it carries the marker if not yet placed, zeros and the length
                    state_next = S_PAD;
                    final_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD)
                    begin
                        // drop back to the initial state for the next message
                        state_next = S_IDLE;
                        fill_next  = '0;
                        len_next   = '0;
                        pad_next   = 1'b0;
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[i] = INIT_H[i];
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            pad_reg     <= 1'b0;
            marker_reg  <= 1'b0;
            final_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            pad_reg     <= pad_next;
            marker_reg  <= marker_next;
            final_reg   <= final_next;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    // working variables: payload, no reset
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule
